// File: rtl/core/clcc_pkg.sv
// Shared types and constants for the locus coverage counter.
package clcc_pkg;

    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned INDEX_W     = 12;
    localparam int unsigned POS_W       = 31;
    localparam int unsigned MASK_W      = 32;
    localparam int unsigned FLAGS_W     = 16;
    localparam int unsigned CODE_W      = 4;
    localparam int unsigned LEN_W       = 28;
    localparam int unsigned CLASS_IDX_W = 5;
    localparam int unsigned OUT_COUNT_W = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CLASS_CNT_W = 6;
    localparam int unsigned LOCI_CFG_W  = 13;
    localparam int unsigned REF_W       = 32;

    localparam logic [FLAGS_W-1:0] REJECT_RESET = 16'h0F04;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_LOCUS = 2'd0,
        OP_BEGIN_READ  = 2'd1,
        OP_CIGAR       = 2'd2,
        OP_END_READ    = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLASS_COUNT = 2'd0,
        CFG_LOCI_IN_USE = 2'd1,
        CFG_REJECT_MASK = 2'd2
    } cfg_index_t;

    localparam logic [CODE_W-1:0] CIGAR_M  = 4'd0;
    localparam logic [CODE_W-1:0] CIGAR_D  = 4'd2;
    localparam logic [CODE_W-1:0] CIGAR_N  = 4'd3;
    localparam logic [CODE_W-1:0] CIGAR_EQ = 4'd7;
    localparam logic [CODE_W-1:0] CIGAR_X  = 4'd8;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  entry_index;
        logic [POS_W-1:0]    position;
        logic [MASK_W-1:0]   class_mask;
        logic [FLAGS_W-1:0]  read_flags;
        logic [CODE_W-1:0]   cigar_code;
        logic [LEN_W-1:0]    op_length;
    } in_word_t;

    typedef struct packed {
        logic [CLASS_IDX_W-1:0] class_index;
        logic                   is_any;
        logic [OUT_COUNT_W-1:0] covered_count;
        logic                   last;
    } out_word_t;

endpackage

// File: rtl/core/clcc_stream_if.sv
// Valid/ready channel carrying one word of a given type.
interface clcc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/clcc_ram.sv
// Generic single-port write, single read port RAM with registered read.
module clcc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/cigar_locus_coverage_counter.sv
// Top level: locus table, read walk, coverage counters and result emitter.
//
// Usage:
//  in  : stream of input words (opcode 0 write locus, 1 begin read, 2 cigar op,
//        3 end read), taken when valid and ready are both high.
//  out : stream of result words, one per class in use and then ANY with last.
//  cfg : write port (cfg_we, cfg_index, cfg_data); the user writes it only when idle, the block does not enforce this.
// The locus table lives in two RAMs (position, class mask) with registered
// reads. Class counters sit in a third RAM of 2**clog2(CLASSES) entries.
// Work per word (ready stays low while it runs, after the word is taken):
//  write locus, I/S/H/P/D/N op, later words of a dropped read : ready stays high.
//  begin read   : clears the class counter RAM, then a lower-bound search of
//                 up to log2(LOCI_DEPTH)+1 steps, each a table read and a
//                 compare, then a last bound check.
//  M/=/X op     : a table read per locus skipped; a table read, then a counter
//                 read-modify-write per class in use, for each locus counted;
//                 then a final table read or bound check ends the walk.
//  end read     : one result word per class in use, then ANY.
// The block takes one word at a time; ready stays low while a word is worked.
// A stalled receiver holds the output register and the emitter waits.
// Reset runs a clearing pass over the counter RAM with ready low.
module cigar_locus_coverage_counter
    import clcc_pkg::*;
#(
    parameter int unsigned LOCI_DEPTH  = 4096,
    parameter int unsigned CLASSES     = 32,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    clcc_stream_if.sink            in,
    clcc_stream_if.source          out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned AW  = $clog2(LOCI_DEPTH);
    localparam int unsigned NW  = AW + 1;
    localparam int unsigned CW  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SRCH_RD, S_SRCH_CMP, S_WALK_RD, S_WALK_CMP,
        S_CNT_RD, S_CNT_WR, S_EMIT_RD, S_EMIT_OUT
    } state_t;

    state_t state_reg;

    logic [CLASS_CNT_W-1:0] class_count_reg;
    logic [LOCI_CFG_W-1:0]  loci_in_use_reg;
    logic [FLAGS_W-1:0]     reject_mask_reg;

    logic [NW-1:0]          cursor_reg, lo_reg, hi_reg;
    logic [REF_W-1:0]       ref_pos_reg, end_pos_reg;
    logic [COUNT_WIDTH-1:0] any_reg;
    logic                   dropped_reg;
    logic [CW:0]            cls_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [POS_W-1:0]       start_reg;
    logic                   skip_reg;
    out_word_t              out_reg;
    logic                   out_valid_reg;

    logic [NW-1:0]          n_loci;
    logic [CW:0]            n_cls;
    logic [NW-1:0]          mid;
    logic [AW-1:0]          tbl_rd_addr;
    logic [POS_W-1:0]       pos_rd;
    logic [MASK_W-1:0]      mask_rd;
    logic [CW-1:0]          cnt_addr;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rd;
    logic [REF_W:0]         end_sum;
    logic                   tbl_we;
    in_word_t               iw;

    assign iw = in.data;

    always_comb
    begin
        if (32'(loci_in_use_reg) > 32'(LOCI_DEPTH))
            n_loci = NW'(LOCI_DEPTH);
        else
            n_loci = NW'(loci_in_use_reg);
        if (class_count_reg == '0)
            n_cls = (CW+1)'(1);
        else if (class_count_reg > CLASS_CNT_W'(CLASSES))
            n_cls = (CW+1)'(CLASSES);
        else
            n_cls = (CW+1)'(class_count_reg);
    end

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign end_sum = {1'b0, ref_pos_reg} + (REF_W+1)'(iw.op_length);

    always_comb
    begin
        if (state_reg == S_SRCH_RD)
            tbl_rd_addr = mid[AW-1:0];
        else
            tbl_rd_addr = cursor_reg[AW-1:0];
    end

    assign tbl_we = in.valid && in.ready && (iw.opcode == OP_WRITE_LOCUS)
                    && (32'(iw.entry_index) < 32'(LOCI_DEPTH));

    clcc_ram #(.WIDTH(POS_W), .DEPTH(LOCI_DEPTH)) u_pos_ram (
        .clk(clk), .wr_en(tbl_we), .wr_addr(AW'(iw.entry_index)),
        .wr_data(iw.position), .rd_addr(tbl_rd_addr), .rd_data(pos_rd)
    );

    clcc_ram #(.WIDTH(MASK_W), .DEPTH(LOCI_DEPTH)) u_mask_ram (
        .clk(clk), .wr_en(tbl_we), .wr_addr(AW'(iw.entry_index)),
        .wr_data(iw.class_mask), .rd_addr(tbl_rd_addr), .rd_data(mask_rd)
    );

    // Class counter RAM: cleared on reset and on begin, bumped per locus, read on end.
    assign cnt_addr  = cls_reg[CW-1:0];
    assign cnt_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_CNT_WR && mask_reg[cls_reg[CW-1:0]]);
    assign cnt_wdata = (state_reg == S_CLEAR) ? '0 :
                       ((cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1);

    clcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << CW)) u_cnt_ram (
        .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_addr), .wr_data(cnt_wdata),
        .rd_addr(cnt_addr), .rd_data(cnt_rd)
    );

    assign in.ready  = (state_reg == S_IDLE);
    assign out.valid = out_valid_reg;
    assign out.data  = out_reg;

    function automatic logic [OUT_COUNT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
        if (COUNT_WIDTH > OUT_COUNT_W && (v >> OUT_COUNT_W) != '0)
            return '1;
        return OUT_COUNT_W'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // clearing pass over the counter RAM, then an empty search to idle
            state_reg       <= S_CLEAR;
            class_count_reg <= CLASS_CNT_W'(1);
            loci_in_use_reg <= '0;
            reject_mask_reg <= REJECT_RESET;
            cursor_reg      <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            ref_pos_reg     <= '0;
            end_pos_reg     <= '0;
            any_reg         <= '0;
            dropped_reg     <= 1'b0;
            cls_reg         <= '0;
            mask_reg        <= '0;
            start_reg       <= '0;
            skip_reg        <= 1'b0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLASS_COUNT: class_count_reg <= cfg_data[CLASS_CNT_W-1:0];
                    CFG_LOCI_IN_USE: loci_in_use_reg <= cfg_data[LOCI_CFG_W-1:0];
                    CFG_REJECT_MASK: reject_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
            // the emitter reloads the output register itself
            if (out_valid_reg && out.ready && state_reg != S_EMIT_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in.valid)
                    begin
                        case (iw.opcode)
                            OP_BEGIN_READ:
                            begin
                                any_reg     <= '0;
                                dropped_reg <= (iw.read_flags & reject_mask_reg) != '0;
                                ref_pos_reg <= REF_W'(iw.position);
                                start_reg   <= iw.position;
                                lo_reg      <= '0;
                                hi_reg      <= n_loci;
                                cls_reg     <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            OP_CIGAR:
                            begin
                                if (!dropped_reg)
                                begin
                                    if (iw.cigar_code == CIGAR_M ||
                                        iw.cigar_code == CIGAR_EQ ||
                                        iw.cigar_code == CIGAR_X)
                                    begin
                                        end_pos_reg <= end_sum[REF_W] ? '1 : end_sum[REF_W-1:0];
                                        skip_reg    <= 1'b1;
                                        state_reg   <= S_WALK_RD;
                                    end
                                    else if (iw.cigar_code == CIGAR_D ||
                                             iw.cigar_code == CIGAR_N)
                                    begin
                                        ref_pos_reg <= end_sum[REF_W] ? '1 : end_sum[REF_W-1:0];
                                    end
                                end
                            end
                            OP_END_READ:
                            begin
                                if (!dropped_reg)
                                begin
                                    cls_reg   <= '0;
                                    state_reg <= S_EMIT_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    if (cls_reg == (CW+1)'(CLASSES - 1))
                        state_reg <= S_SRCH_RD;
                    cls_reg <= cls_reg + 1'b1;
                end
                S_SRCH_RD:
                begin
                    if (lo_reg < hi_reg)
                        state_reg <= S_SRCH_CMP;
                    else
                    begin
                        cursor_reg <= lo_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                S_SRCH_CMP:
                begin
                    if (pos_rd < start_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                    state_reg <= S_SRCH_RD;
                end
                S_WALK_RD:
                begin
                    if (cursor_reg < n_loci)
                        state_reg <= S_WALK_CMP;
                    else
                    begin
                        ref_pos_reg <= end_pos_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                S_WALK_CMP:
                begin
                    if (skip_reg && REF_W'(pos_rd) < ref_pos_reg)
                    begin
                        cursor_reg <= cursor_reg + 1'b1;
                        state_reg  <= S_WALK_RD;
                    end
                    else if (REF_W'(pos_rd) < end_pos_reg)
                    begin
                        skip_reg   <= 1'b0;
                        mask_reg   <= mask_rd;
                        any_reg    <= (any_reg == CNT_MAX) ? any_reg : any_reg + 1'b1;
                        cursor_reg <= cursor_reg + 1'b1;
                        cls_reg    <= '0;
                        state_reg  <= S_CNT_RD;
                    end
                    else
                    begin
                        ref_pos_reg <= end_pos_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                S_CNT_RD:
                begin
                    state_reg <= S_CNT_WR;
                end
                S_CNT_WR:
                begin
                    if (cls_reg + 1'b1 >= n_cls)
                    begin
                        skip_reg  <= 1'b0;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        state_reg <= S_CNT_RD;
                    end
                    cls_reg <= cls_reg + 1'b1;
                end
                S_EMIT_RD:
                begin
                    if (!out_valid_reg || out.ready)
                        state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    if (!out_valid_reg || out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (cls_reg < n_cls)
                        begin
                            out_reg.class_index   <= CLASS_IDX_W'(cls_reg);
                            out_reg.is_any        <= 1'b0;
                            out_reg.covered_count <= sat_out(cnt_rd);
                            out_reg.last          <= 1'b0;
                            cls_reg   <= cls_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            out_reg.class_index   <= '0;
                            out_reg.is_any        <= 1'b1;
                            out_reg.covered_count <= sat_out(any_reg);
                            out_reg.last          <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result word changed under stall");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready |-> !(state_reg == S_WALK_RD || state_reg == S_CNT_WR))
        else $error("ready while working");
    a_last_any: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.last == out_reg.is_any)
        else $error("last not on ANY");
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_CMP |-> lo_reg < hi_reg && hi_reg <= n_loci)
        else $error("search bounds broken");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the locus coverage counter: directed rows, then random reads.
module tb_top;
    import clcc_pkg::*;

    localparam int unsigned DEPTH = 4096;
    localparam int unsigned NCLS  = 32;
    localparam int unsigned CMAX  = 65535;

    typedef struct {
        bit          is_cfg;
        cfg_index_t  reg_sel;
        int unsigned reg_val;
        in_word_t    word;
        bit          any_known;
        int unsigned any_val;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    clcc_stream_if #(.T(in_word_t))  in_ch ();
    clcc_stream_if #(.T(out_word_t)) out_ch ();

    cigar_locus_coverage_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // shadow of the block
    int unsigned locus_pos [DEPTH];
    bit [31:0]   locus_cls [DEPTH];
    int unsigned walk_cursor;
    bit [31:0]   ref_pos;
    int unsigned class_hits [NCLS];
    int unsigned any_hits;
    bit          dropped;
    int unsigned n_classes_reg;
    int unsigned loci_reg;
    bit [15:0]   reject_reg;

    out_word_t   pending_counts [$];
    int          mismatches;
    int          words_sent;
    int          counts_seen;
    int          reads_begun;
    bit          calm;

    function automatic int unsigned loci_active();
        return (loci_reg > DEPTH) ? DEPTH : loci_reg;
    endfunction

    function automatic int unsigned classes_active();
        if (n_classes_reg == 0)
            return 1;
        return (n_classes_reg > NCLS) ? NCLS : n_classes_reg;
    endfunction

    function automatic bit [31:0] step_ref(bit [31:0] r, int unsigned len);
        longint unsigned e;
        e = longint'(r) + len;
        return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    function automatic int unsigned sat_inc(int unsigned v);
        return (v < CMAX) ? v + 1 : v;
    endfunction

    // Updates the shadow for one accepted word; end of read queues its counts.
    function automatic void track_word(in_word_t w);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned n;
        bit [31:0]   stop;
        out_word_t   o;
        case (opcode_t'(w.opcode))
            OP_WRITE_LOCUS:
            begin
                locus_pos[w.entry_index] = w.position;
                locus_cls[w.entry_index] = w.class_mask;
            end
            OP_BEGIN_READ:
            begin
                foreach (class_hits[i])
                    class_hits[i] = 0;
                any_hits = 0;
                dropped = (w.read_flags & reject_reg) != 0;
                lo = 0;
                hi = loci_active();
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (locus_pos[mid] < w.position)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                walk_cursor = lo;
                ref_pos = {1'b0, w.position};
                reads_begun++;
            end
            OP_CIGAR:
            begin
                if (!dropped)
                begin
                    if (w.cigar_code inside {CIGAR_M, CIGAR_EQ, CIGAR_X})
                    begin
                        n = loci_active();
                        stop = step_ref(ref_pos, w.op_length);
                        while (walk_cursor < n && locus_pos[walk_cursor] < ref_pos)
                            walk_cursor++;
                        while (walk_cursor < n && locus_pos[walk_cursor] < stop)
                        begin
                            any_hits = sat_inc(any_hits);
                            for (int b = 0; b < classes_active(); b++)
                                if (locus_cls[walk_cursor][b])
                                    class_hits[b] = sat_inc(class_hits[b]);
                            walk_cursor++;
                        end
                        ref_pos = stop;
                    end
                    else if (w.cigar_code inside {CIGAR_D, CIGAR_N})
                        ref_pos = step_ref(ref_pos, w.op_length);
                end
            end
            OP_END_READ:
            begin
                if (!dropped)
                begin
                    for (int c = 0; c < classes_active(); c++)
                    begin
                        o.class_index   = c[4:0];
                        o.is_any        = 1'b0;
                        o.covered_count = class_hits[c][15:0];
                        o.last          = 1'b0;
                        pending_counts = {pending_counts, o};
                    end
                    o.class_index   = '0;
                    o.is_any        = 1'b1;
                    o.covered_count = any_hits[15:0];
                    o.last          = 1'b1;
                    pending_counts = {pending_counts, o};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic send_word(in_word_t w);
        int g;
        g = draw_gap();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_word(w);
        words_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        // words with no result may still be walking the table
        do
            @(posedge clk);
        while (!in_ch.ready);
        repeat (8) @(posedge clk);
    endtask

    // call only after wait_idle
    task automatic write_reg(cfg_index_t sel, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (sel)
            CFG_CLASS_COUNT: n_classes_reg = val & 6'h3F;
            CFG_LOCI_IN_USE: loci_reg = val & 13'h1FFF;
            CFG_REJECT_MASK: reject_reg = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic in_word_t mk(opcode_t op, int unsigned idx, bit [30:0] pos,
                                    bit [31:0] msk, bit [15:0] flg, bit [3:0] code,
                                    bit [27:0] len);
        in_word_t w;
        w.opcode      = op;
        w.entry_index = idx[11:0];
        w.position    = pos;
        w.class_mask  = msk;
        w.read_flags  = flg;
        w.cigar_code  = code;
        w.op_length   = len;
        return w;
    endfunction

    function automatic row_t wrow(in_word_t w, bit known = 0, int unsigned any_v = 0);
        row_t r;
        r.is_cfg    = 0;
        r.reg_sel   = CFG_CLASS_COUNT;
        r.reg_val   = 0;
        r.word      = w;
        r.any_known = known;
        r.any_val   = any_v;
        return r;
    endfunction

    function automatic row_t crow(cfg_index_t sel, int unsigned val);
        row_t r;
        r = wrow('0);
        r.is_cfg  = 1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // Writes slots 0..n-1, sorted unless scrambled; loci_val must not exceed n.
    task automatic load_table(int unsigned n, bit scrambled, int unsigned loci_val);
        int unsigned p;
        bit [31:0]   m;
        p = $urandom_range(0, 40);
        for (int unsigned i = 0; i < n; i++)
        begin
            p = scrambled ? $urandom_range(0, 400) : p + $urandom_range(0, 12);
            case ($urandom_range(0, 5))
                0: m = 32'hFFFF_FFFF;
                1: m = 32'h0;
                default: m = $urandom;
            endcase
            send_word(mk(OP_WRITE_LOCUS, i, p[30:0], m, 16'($urandom), 4'($urandom),
                         28'($urandom)));
        end
        wait_idle();
        write_reg(CFG_LOCI_IN_USE, loci_val);
    endtask

    task automatic random_read(int unsigned span);
        int unsigned k;
        bit [3:0]    code;
        bit [27:0]   len;
        bit [15:0]   flg;
        flg = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0;
        send_word(mk(OP_BEGIN_READ, $urandom, 31'($urandom_range(0, span)), $urandom, flg,
                     4'($urandom), 28'($urandom)));
        k = $urandom_range(1, 6);
        repeat (k)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: code = CIGAR_M;
                3:       code = CIGAR_EQ;
                4:       code = CIGAR_X;
                5:       code = CIGAR_D;
                6:       code = CIGAR_N;
                default: code = 4'($urandom_range(0, 15));
            endcase
            len = ($urandom_range(0, 25) == 0) ? 28'($urandom) : 28'($urandom_range(0, 60));
            send_word(mk(OP_CIGAR, $urandom, 31'($urandom), $urandom, 16'($urandom), code,
                         len));
        end
        if ($urandom_range(0, 9) != 0)
            send_word(mk(OP_END_READ, $urandom, 31'($urandom), $urandom, 16'($urandom),
                         4'($urandom), 28'($urandom)));
    endtask

    // result side
    initial
    begin
        int g;
        out_word_t want;
        out_ch.ready <= 1'b0;
        forever
        begin
            g = draw_gap();
            if (g > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && rst_n));
            counts_seen++;
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected count word %p", out_ch.data);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (out_ch.data.class_index !== want.class_index ||
                    out_ch.data.is_any !== want.is_any ||
                    out_ch.data.covered_count !== want.covered_count ||
                    out_ch.data.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: count word exp %p got %p", want, out_ch.data);
                end
            end
        end
    end

    initial
    begin
        #(12 * 3_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        row_t        rows [$];
        int          q0;
        int unsigned n_tab;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        n_classes_reg = 1;
        loci_reg      = 0;
        reject_reg    = REJECT_RESET;
        walk_cursor   = 0;
        ref_pos       = 0;
        any_hits      = 0;
        dropped       = 0;
        foreach (class_hits[i])
            class_hits[i] = 0;
        mismatches    = 0;
        words_sent    = 0;
        counts_seen   = 0;
        reads_begun   = 0;
        calm          = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counts out of reset, cigar op before any read
        rows = {rows, wrow(mk(OP_END_READ, 0, 0, 0, 0, 0, 0), 1, 0)};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_M, 28'hFFF_FFFF))};
        rows = {rows, wrow(mk(OP_END_READ, 0, 0, 0, 0, 0, 0), 1, 0)};
        for (int i = 0; i < 8; i++)
            rows = {rows, wrow(mk(OP_WRITE_LOCUS, i, 31'(10 * (i + 1)),
                                  (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 :
                                  (i == 2) ? 32'h8000_0000 : 32'h1 << (i * 4), 0, 0, 0))};
        rows = {rows, wrow(mk(OP_WRITE_LOCUS, 4095, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                              16'hFFFF, 4'hF, 28'hFFF_FFFF))};
        rows = {rows, crow(CFG_LOCI_IN_USE, 8)};
        rows = {rows, crow(CFG_CLASS_COUNT, 32)};
        rows = {rows, wrow(mk(OP_BEGIN_READ, 0, 15, 0, 0, 0, 0))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_M, 30))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_D, 10))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_X, 11))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, 4'd1, 100))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_EQ, 0))};
        rows = {rows, wrow(mk(OP_END_READ, 0, 0, 0, 0, 0, 0), 1, 4)};
        // read dropped by a flag in the reject mask
        rows = {rows, wrow(mk(OP_BEGIN_READ, 0, 0, 0, 16'h0004, 0, 0))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_M, 100))};
        rows = {rows, wrow(mk(OP_END_READ, 0, 0, 0, 0, 0, 0))};
        // start past every locus, reference pushed further by an N op
        rows = {rows, wrow(mk(OP_BEGIN_READ, 0, 31'h7FFF_FFFF, 0, 0, 0, 0))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_N, 28'hFFF_FFFF))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, 4'hF, 28'hFFF_FFFF))};
        rows = {rows, wrow(mk(OP_END_READ, 0, 0, 0, 0, 0, 0), 1, 0)};
        rows = {rows, crow(CFG_CLASS_COUNT, 0)};
        rows = {rows, crow(CFG_REJECT_MASK, 0)};
        rows = {rows, wrow(mk(OP_BEGIN_READ, 0, 0, 0, 16'hFFFF, 0, 0))};
        rows = {rows, wrow(mk(OP_CIGAR, 0, 0, 0, 0, CIGAR_M, 28'hFFF_FFFF))};
        rows = {rows, wrow(mk(OP_END_READ, 0, 0, 0, 0, 0, 0), 1, 8)};

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(rows[i].reg_sel, rows[i].reg_val);
            end
            else
            begin
                q0 = pending_counts.size();
                send_word(rows[i].word);
                // typed ANY count replaces the shadow's value
                if (rows[i].any_known && pending_counts.size() > q0)
                    pending_counts[pending_counts.size() - 1].covered_count =
                        rows[i].any_val[15:0];
            end
        end

        // random phases
        for (int ph = 0; ph < 8 && words_sent < 180; ph++)
        begin
            wait_idle();
            calm = (ph == 2);
            case (ph % 4)
                0: write_reg(CFG_CLASS_COUNT, 32);
                1: write_reg(CFG_CLASS_COUNT, 1);
                default: write_reg(CFG_CLASS_COUNT, $urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_REJECT_MASK, 16'hFFFF);
                1: write_reg(CFG_REJECT_MASK, REJECT_RESET);
                default: write_reg(CFG_REJECT_MASK, $urandom_range(0, 65535));
            endcase
            if (ph == 1)
                load_table(0, 0, 0);
            else
            begin
                n_tab = $urandom_range(1, 12);
                load_table(n_tab, ph == 2 || ph == 5, $urandom_range(0, n_tab));
            end
            for (int r = 0; r < 8 && words_sent < 180; r++)
            begin
                random_read(500);
                if (ph == 1 && r == 1)
                begin
                    // hold the sender until every count has drained
                    in_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (pending_counts.size() != 0)
                        @(posedge clk);
                end
            end
            calm = 0;
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Run covered %0d input words, %0d reads begun, %0d count words checked.",
                 words_sent, reads_begun, counts_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_counts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
